### src/cbd_pkg.sv
// cbd_pkg: shared constants and types for the census bit descriptor.
// No dependencies; every other file of the block but cbd_ram imports it.
package cbd_pkg;

  // Image geometry
  localparam int IMAGE_WIDTH  = 28;
  localparam int IMAGE_HEIGHT = 28;
  localparam int MARGIN       = 6;

  // Field widths
  localparam int PIXEL_W = 8;
  localparam int HALF_W  = PIXEL_W - 1;   // pixel after the right shift by one
  localparam int WORD_W  = 32;

  // Position counters
  localparam int COL_W = $clog2(IMAGE_WIDTH);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT);

  // Line buffer: two earlier rows, one halved pixel each, per column
  localparam int LINE_W = 2 * HALF_W;

  // Interior window of the pixel that completes a center (one row down, one column right)
  localparam int ROW_LO = MARGIN + 1;
  localparam int ROW_HI = IMAGE_HEIGHT - MARGIN;
  localparam int COL_LO = MARGIN + 1;
  localparam int COL_HI = IMAGE_WIDTH - MARGIN;

  // Four comparisons per center; centers per word
  localparam int NB_COUNT = 4;
  localparam int NIB_NUM  = WORD_W / NB_COUNT;
  localparam int NIB_W    = $clog2(NIB_NUM);

  // Comparison result of one center, window stage to packer
  typedef struct packed {
    logic                valid;  // center evaluated this cycle
    logic                last;   // final center of the image
    logic [NB_COUNT-1:0] cmp;    // bit 0 lower-right, bit 1 lower-left, bit 2 upper-right, bit 3 upper-left
  } cbd_bits_t;

endpackage

### src/cbd_pix_if.sv
// cbd_pix_if: pixel channel, valid/ready with one gray pixel.
// Depends on cbd_pkg.
interface cbd_pix_if;
  import cbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

### src/cbd_word_if.sv
// cbd_word_if: result channel, valid/ready with a 32-bit census word and end-of-image flag.
// Depends on cbd_pkg.
interface cbd_word_if;
  import cbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] bit_word;
  logic              last_word;

  modport source (output valid, output bit_word, output last_word, input ready);
  modport sink   (input valid, input bit_word, input last_word, output ready);
endinterface

### src/cbd_ram.sv
// cbd_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module cbd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/cbd_window.sv
// cbd_window: position counters, line buffer read/modify/write and the 3x3 window
// that compares each interior center with its diagonal neighbors.
// Depends on cbd_pkg; drives a cbd_ram instance placed in the top level.
module cbd_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pix_take,
  input  logic [cbd_pkg::PIXEL_W-1:0] pix,
  output logic                      rd_en,
  output logic [cbd_pkg::COL_W-1:0] rd_addr,
  input  logic [cbd_pkg::LINE_W-1:0] rd_data,
  output logic                      wr_en,
  output logic [cbd_pkg::COL_W-1:0] wr_addr,
  output logic [cbd_pkg::LINE_W-1:0] wr_data,
  output cbd_pkg::cbd_bits_t        bits
);
  import cbd_pkg::*;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              s1_v_r;
  logic [HALF_W-1:0] s1_pix_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              s1_int_r;
  logic              s1_last_r;
  logic              interior;
  logic              last_ctr;

  // Window taps: row r (current), r-1, r-2; suffix = columns back from current
  logic [HALF_W-1:0] r0_1_r, r0_2_r, r1_1_r, r2_1_r, r2_2_r;
  logic [HALF_W-1:0] up1_pix;   // row r-1 at current column
  logic [HALF_W-1:0] up2_pix;   // row r-2 at current column

  // Stage 0: position and read issue
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (pix_take) begin
      if (col_r == COL_W'(IMAGE_WIDTH - 1)) begin
        col_nxt = '0;
        if (row_r == ROW_W'(IMAGE_HEIGHT - 1)) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  assign interior = (int'(row_r) >= ROW_LO) && (int'(row_r) <= ROW_HI) &&
                    (int'(col_r) >= COL_LO) && (int'(col_r) <= COL_HI);
  assign last_ctr = (int'(row_r) == ROW_HI) && (int'(col_r) == COL_HI);

  assign rd_en   = pix_take;
  assign rd_addr = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= pix_take;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s1_pix_r  <= pix[PIXEL_W-1:1];
      s1_col_r  <= col_r;
      s1_int_r  <= interior;
      s1_last_r <= last_ctr;
    end
  end

  // Stage 1: line data arrives; age both rows and write back
  assign up1_pix = rd_data[HALF_W-1:0];
  assign up2_pix = rd_data[LINE_W-1:HALF_W];

  assign wr_en   = s1_v_r;
  assign wr_addr = s1_col_r;
  assign wr_data = {up1_pix, s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      r0_1_r <= s1_pix_r;
      r0_2_r <= r0_1_r;
      r1_1_r <= up1_pix;
      r2_1_r <= up2_pix;
      r2_2_r <= r2_1_r;
    end
  end

  // Center is row r-1, column c-1
  always_comb begin
    bits.valid  = s1_v_r && s1_int_r;
    bits.last   = s1_last_r;
    bits.cmp[0] = r1_1_r > s1_pix_r;  // lower-right
    bits.cmp[1] = r1_1_r > r0_2_r;    // lower-left
    bits.cmp[2] = r1_1_r > up2_pix;   // upper-right
    bits.cmp[3] = r1_1_r > r2_2_r;    // upper-left
  end

endmodule

### src/cbd_packer.sv
// cbd_packer: packs comparison nibbles into 32-bit words and buffers up to two words
// for the result channel. Depends on cbd_pkg.
module cbd_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cbd_pkg::cbd_bits_t         bits,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [cbd_pkg::WORD_W-1:0] out_word,
  output logic                       out_last,
  output logic                       room
);
  import cbd_pkg::*;

  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [NIB_W-1:0]  nib_r, nib_nxt;
  logic [WORD_W-1:0] word;
  logic              emit;

  logic              head_v_r, head_v_nxt;
  logic [WORD_W-1:0] head_w_r, head_w_nxt;
  logic              head_l_r, head_l_nxt;
  logic              skid_v_r, skid_v_nxt;
  logic [WORD_W-1:0] skid_w_r, skid_w_nxt;
  logic              skid_l_r, skid_l_nxt;
  logic              pop;
  logic [1:0]        load;

  assign word = acc_r | (WORD_W'(bits.cmp) << (int'(nib_r) * NB_COUNT));
  assign emit = bits.valid && ((nib_r == NIB_W'(NIB_NUM - 1)) || bits.last);

  always_comb begin
    acc_nxt = acc_r;
    nib_nxt = nib_r;
    if (emit) begin
      acc_nxt = '0;
      nib_nxt = '0;
    end else if (bits.valid) begin
      acc_nxt = word;
      nib_nxt = nib_r + 1'b1;
    end
  end

  // Two-entry output buffer
  assign pop = head_v_r && out_ready;

  always_comb begin
    head_v_nxt = head_v_r;
    head_w_nxt = head_w_r;
    head_l_nxt = head_l_r;
    skid_v_nxt = skid_v_r;
    skid_w_nxt = skid_w_r;
    skid_l_nxt = skid_l_r;
    if (pop) begin
      head_v_nxt = skid_v_r;
      head_w_nxt = skid_w_r;
      head_l_nxt = skid_l_r;
      skid_v_nxt = 1'b0;
    end
    if (emit) begin
      if (!head_v_nxt) begin
        head_v_nxt = 1'b1;
        head_w_nxt = word;
        head_l_nxt = bits.last;
      end else begin
        skid_v_nxt = 1'b1;
        skid_w_nxt = word;
        skid_l_nxt = bits.last;
      end
    end
  end

  // A pixel taken now may push a word next cycle: keep one slot free for it
  assign load = 2'(head_v_r) + 2'(skid_v_r) + 2'(emit);
  assign room = (load - 2'(pop)) <= 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      nib_r    <= '0;
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      nib_r    <= nib_nxt;
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_w_r <= head_w_nxt;
    head_l_r <= head_l_nxt;
    skid_w_r <= skid_w_nxt;
    skid_l_r <= skid_l_nxt;
  end

  assign out_valid = head_v_r;
  assign out_word  = head_w_r;
  assign out_last  = head_l_r;

endmodule

### src/census_bit_descriptor.sv
// census_bit_descriptor: top level of the diagonal census bit descriptor.
// Depends on cbd_pkg, cbd_pix_if, cbd_word_if, cbd_ram, cbd_window, cbd_packer.
//
//   Channel   Dir   Handshake       Payload
//   in_ch     in    valid / ready   pixel[7:0]      gray pixel, raster order
//   out_ch    out   valid / ready   bit_word[31:0]  census bits, first comparison in bit 0
//                                   last_word       final word of the image
//
// One pixel per clock sustained while in_ch.ready is high: each pixel takes one line-buffer
// read in the cycle of its transfer and the write-back of the same column in the next cycle.
// The pixel that completes a word is registered in the window's stage 1, and the word is
// then registered into the output buffer before it is valid on out_ch. Reset (rst_n low,
// synchronous) restarts at the first pixel of an image and drops any buffered words; line
// buffer contents are not cleared. in_ch.ready is low whenever both output slots would hold
// a word after this edge (counting the word in flight and any out_ch transfer this cycle).
module census_bit_descriptor (
  input logic       clk,
  input logic       rst_n,
  cbd_pix_if.sink   in_ch,
  cbd_word_if.source out_ch
);
  import cbd_pkg::*;

  logic              pix_take;
  logic              room;
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr;
  logic [LINE_W-1:0] rd_data;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [LINE_W-1:0] wr_data;
  cbd_bits_t         bits;

  assign in_ch.ready = room;
  assign pix_take    = in_ch.valid && in_ch.ready;

  // Line buffer: per column, halved pixels of rows r-1 (low half) and r-2 (high half)
  cbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (IMAGE_WIDTH),
    .ADDR_W(COL_W)
  ) u_line (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Counters, window and the four comparisons
  cbd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .pix_take(pix_take),
    .pix     (in_ch.pixel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .bits    (bits)
  );

  // Word assembly and output buffering
  cbd_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .bits     (bits),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_word (out_ch.bit_word),
    .out_last (out_ch.last_word),
    .room     (room)
  );

endmodule

### src/cbd_checker.sv
// cbd_checker: port-level assertions for census_bit_descriptor, attached by bind.
// Depends on cbd_pkg and the top level's interface ports.
module cbd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cbd_pkg::WORD_W-1:0] bit_word,
  input logic                       last_word
);
  import cbd_pkg::*;

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bit_word) && $stable(last_word))
    else $error("result word changed while stalled");

  // Reset empties the output buffer
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Nothing buffered means room for a pixel
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A new word follows a pixel transfer via window stage 1 and the output buffer
  a_word_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without a preceding pixel transfer");

endmodule

bind census_bit_descriptor cbd_checker u_cbd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .bit_word (out_ch.bit_word),
  .last_word(out_ch.last_word)
);
